/* rtl/pbms_pkg.sv */
// ----------------------------------------------------------------------------
// pbms_pkg
// shared types, constants and helpers for the powers-of-base modular scaler
// ----------------------------------------------------------------------------
package pbms_pkg;

    localparam int WORD_BITS_DEF = 64;
    localparam int Q_BITS        = 64;
    localparam int IDX_BITS      = 6;
    localparam int CFG_IDX_BITS  = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BASE_BITS = 2'd1;

    typedef struct packed {
        logic [IDX_BITS-1:0] idx;
        logic                last;
        logic                vend;
    } t_meta;

    // x + y mod q with x, y < q
    function automatic logic [Q_BITS-1:0] add_mod(input logic [Q_BITS-1:0] x,
                                                  input logic [Q_BITS-1:0] y,
                                                  input logic [Q_BITS-1:0] q);
        logic [Q_BITS:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, q}) begin
            s = s - {1'b0, q};
        end
        return s[Q_BITS-1:0];
    endfunction

    // position of the leading one, zero for zero and one
    function automatic logic [IDX_BITS-1:0] lead_one(input logic [Q_BITS-1:0] v);
        logic [IDX_BITS-1:0] p;
        p = '0;
        for (int k = 0; k < Q_BITS; k++) begin
            if (v[k]) begin
                p = IDX_BITS'(k);
            end
        end
        return p;
    endfunction

endpackage

/* rtl/powers_of_base_mod_scaler_unit.sv */
// ----------------------------------------------------------------------------
// powers_of_base_mod_scaler_unit
// scales each coefficient by 2^(i*base_bits) mod q for every window i
//
//  channel  | dir | tdata                         | tlast       | tuser
//  s        | in  | coefficient                   | vector_end  | -
//  m        | out | scaled_value, window_index    | last_window | vector_end_out
//  cfg      | in  | modulus (0), base_bits (1)    | -           | -
//
//  one result per cycle while m is not stalled; the window sequencer takes the next
//  coefficient only as the last of its windows (1 + floor(log2 q) / base_bits) issues
//  results pass through the modular multiplier pipeline and an output register
//  synchronous active-low reset clears valid bits; q=2, base_bits=1 after reset
//  a stall on m freezes the whole pipeline, nothing lost or repeated
// ----------------------------------------------------------------------------
module powers_of_base_mod_scaler_unit #(
    parameter int WORD_BITS = pbms_pkg::WORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [63:0]                       i_s_tdata,   // coefficient
    input  logic                              i_s_tlast,   // vector_end
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [71:0]                       o_m_tdata,   // scaled_value, window_index
    output logic                              o_m_tlast,   // last_window
    output logic                              o_m_tuser,   // vector_end_out
    input  logic                              i_cfg_we,
    input  logic [pbms_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [63:0]                       i_cfg_wdata
);
    import pbms_pkg::*;

    logic [Q_BITS-1:0]   r_q;
    logic [IDX_BITS-1:0] r_lead;
    logic [IDX_BITS-1:0] r_bb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q    <= Q_BITS'(2);
            r_lead <= IDX_BITS'(1);
            r_bb   <= IDX_BITS'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODULUS: begin
                    r_q    <= i_cfg_wdata;
                    r_lead <= lead_one(i_cfg_wdata);
                end
                REG_BASE_BITS: begin
                    r_bb <= (i_cfg_wdata[IDX_BITS-1:0] == '0) ? IDX_BITS'(1)
                                                             : i_cfg_wdata[IDX_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // window sequencer
    logic                 r_busy;
    logic [WORD_BITS-1:0] r_c;
    logic                 r_vend;
    logic [IDX_BITS-1:0]  r_e;
    logic [IDX_BITS-1:0]  r_idx;
    logic                 r_ov;
    logic [Q_BITS-1:0]    r_res;
    t_meta                r_om;

    logic                 adv;
    logic                 cur_last;
    logic [IDX_BITS:0]    e_next;
    logic [Q_BITS-1:0]    pow;
    logic [Q_BITS-1:0]    scale;
    logic                 issue;
    logic                 s_xfer;
    t_meta                iss_meta;
    logic                 p_v;
    logic [Q_BITS-1:0]    p_res;
    t_meta                p_m;

    assign adv      = !r_ov || i_m_tready;
    assign e_next   = {1'b0, r_e} + {1'b0, r_bb};
    assign cur_last = (r_q == '0) || (e_next > {1'b0, r_lead});
    assign pow      = Q_BITS'(1) << r_e;
    assign scale    = ((r_q == '0) || (pow == r_q)) ? '0 : pow;
    assign issue    = r_busy && adv;
    assign o_s_tready = !r_busy || (adv && cur_last);
    assign s_xfer   = i_s_tvalid && o_s_tready;

    assign iss_meta.idx  = r_idx;
    assign iss_meta.last = cur_last;
    assign iss_meta.vend = r_vend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (s_xfer) begin
            r_busy <= 1'b1;
        end else if (issue && cur_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_c    <= i_s_tdata[WORD_BITS-1:0];
            r_vend <= i_s_tlast;
            r_e    <= '0;
            r_idx  <= '0;
        end else if (issue) begin
            r_e   <= e_next[IDX_BITS-1:0];
            r_idx <= r_idx + IDX_BITS'(1);
        end
    end

    pbms_mulpipe #(
        .WORD_BITS(WORD_BITS)
    ) u_mulpipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_valid  (r_busy),
        .i_scale  (scale),
        .i_coef   (r_c),
        .i_meta   (iss_meta),
        .i_q      (r_q),
        .o_valid  (p_v),
        .o_result (p_res),
        .o_meta   (p_m)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= p_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= p_res;
            r_om  <= p_m;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {2'b00, r_om.idx, r_res};
    assign o_m_tlast  = r_om.last;
    assign o_m_tuser  = r_om.vend;

`ifndef SYNTHESIS
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_xfer |=> r_busy)
        else $error("sequencer not busy after input transfer");
    a_first_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_idx == '0) |-> (r_e == '0))
        else $error("first window with nonzero exponent");
    a_zero_mod_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_q == '0) |-> (cur_last && r_idx == '0))
        else $error("zero modulus gave more than one window");
`endif

endmodule

/* rtl/pbms_mulpipe.sv */
// ----------------------------------------------------------------------------
// pbms_mulpipe
// bit-serial modular multiplier unrolled into a pipeline, one stage per
// doubling and one per conditional add, msb of the coefficient first
// ----------------------------------------------------------------------------
module pbms_mulpipe #(
    parameter int WORD_BITS = pbms_pkg::WORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [pbms_pkg::Q_BITS-1:0] i_scale,
    input  logic [WORD_BITS-1:0]        i_coef,
    input  pbms_pkg::t_meta             i_meta,
    input  logic [pbms_pkg::Q_BITS-1:0] i_q,
    output logic                        o_valid,
    output logic [pbms_pkg::Q_BITS-1:0] o_result,
    output pbms_pkg::t_meta             o_meta
);
    import pbms_pkg::*;

    localparam int NSTG = 2 * WORD_BITS;

    logic              r_v [NSTG];
    logic [Q_BITS-1:0] r_r [NSTG];
    logic [Q_BITS-1:0] r_a [NSTG];
    logic [WORD_BITS-1:0] r_c [NSTG];
    t_meta             r_m [NSTG];

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic              p_v;
        logic [Q_BITS-1:0] p_r;
        logic [Q_BITS-1:0] p_a;
        logic [WORD_BITS-1:0] p_c;
        t_meta             p_m;
        logic [Q_BITS-1:0] n_r;

        if (s == 0) begin : g_src_in
            assign p_v = i_valid;
            assign p_r = '0;
            assign p_a = i_scale;
            assign p_c = i_coef;
            assign p_m = i_meta;
        end else begin : g_src_prev
            assign p_v = r_v[s-1];
            assign p_r = r_r[s-1];
            assign p_a = r_a[s-1];
            assign p_c = r_c[s-1];
            assign p_m = r_m[s-1];
        end

        if (s % 2 == 0) begin : g_dbl
            assign n_r = add_mod(p_r, p_r, i_q);
        end else begin : g_add
            assign n_r = p_c[WORD_BITS-1-s/2] ? add_mod(p_r, p_a, i_q) : p_r;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_en) begin
                r_v[s] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[s] <= n_r;
                r_a[s] <= p_a;
                r_c[s] <= p_c;
                r_m[s] <= p_m;
            end
        end
    end

    assign o_valid  = r_v[NSTG-1];
    assign o_result = r_r[NSTG-1];
    assign o_meta   = r_m[NSTG-1];

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the powers-of-base modular scaler: a directed table, special settings with edge
// coefficients, then random coefficients under several modulus and window settings, every result
// compared with an internal model, random stalls on both stream sides
// ----------------------------------------------------------------------------
module tb_top;
    import pbms_pkg::*;

    typedef struct packed {
        logic [63:0] value;
        logic [5:0]  idx;
        logic        last;
        logic        vend;
    } t_scaled;

    typedef struct {
        logic [63:0] coef;
        logic        vend;
        logic        fixed;
        logic [63:0] value0;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [71:0] o_m_tdata;
    logic        o_m_tlast;
    logic        o_m_tuser;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = REG_MODULUS;
    logic [63:0] i_cfg_wdata = '0;

    logic [63:0] cur_q = 64'd2;
    logic [5:0]  cur_b = 6'd1;
    t_scaled     scaled_q[$];
    int          errors = 0;
    int          cycles = 0;
    bit          calm = 1'b0;
    t_row        rows[$];

    powers_of_base_mod_scaler_unit DUT (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] q);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return 64'(p % {64'd0, q});
    endfunction

    function automatic int top_bit(logic [63:0] v);
        int p;
        p = 0;
        for (int k = 0; k < 64; k++) if (v[k]) p = k;
        return p;
    endfunction

    task automatic predict_scaled(logic [63:0] c, logic v);
        int b, w;
        t_scaled r;
        b = (cur_b == 0) ? 1 : cur_b;
        if (cur_q == 0) begin
            r = '{64'd0, 6'd0, 1'b1, v};
            scaled_q.push_back(r);
            return;
        end
        w = 1 + top_bit(cur_q) / b;
        for (int i = 0; i < w; i++) begin
            r.value = mulmod(c, (64'd1 << (i * b)) % cur_q, cur_q);
            r.idx = 6'(i);
            r.last = (i + 1 == w);
            r.vend = v;
            scaled_q.push_back(r);
        end
    endtask

    // receiver with random stall bursts
    initial begin
        int n;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                n = $urandom_range(1, 10);
                repeat (n) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_scaled e;
        cycles <= cycles + 1;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (scaled_q.size() == 0) begin
                $display("%0t unexpected result %h", $time, o_m_tdata);
                errors <= errors + 1;
            end else begin
                e = scaled_q.pop_front();
                if (o_m_tdata != {e.idx, e.value} || o_m_tlast != e.last
                        || o_m_tuser != e.vend) begin
                    $display("%0t mismatch exp %h/%h/%b/%b act %h/%h/%b/%b", $time,
                             e.value, e.idx, e.last, e.vend, o_m_tdata[63:0],
                             o_m_tdata[69:64], o_m_tlast, o_m_tuser);
                    errors <= errors + 1;
                end
            end
        end
        if (cycles > 2000000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_MODULUS) cur_q = d;
        else cur_b = d[5:0];
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (scaled_q.size() != 0) @(posedge i_clk);
        repeat (140) @(posedge i_clk);
    endtask

    task automatic send_coef(logic [63:0] c, logic v);
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            n = $urandom_range(1, 10);
            repeat (n) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= c;
        i_s_tlast <= v;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_scaled(c, v);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial begin
        logic [63:0] qs[8];
        int bs[8];
        logic [63:0] c;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset q=2, b=1: two windows, value0 = c mod 2
        rows.push_back('{64'd0, 1'b0, 1'b1, 64'd0});
        rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'd1});
        rows.push_back('{64'd3, 1'b0, 1'b1, 64'd1});
        rows.push_back('{64'h8000_0000_0000_0000, 1'b1, 1'b1, 64'd0});
        foreach (rows[k]) begin
            send_coef(rows[k].coef, rows[k].vend);
            if (rows[k].fixed && scaled_q[scaled_q.size() - 2].value != rows[k].value0) begin
                $display("%0t table row %0d exp %h", $time, k, rows[k].value0);
                errors++;
            end
        end
        drain();

        qs = '{64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 64'd0, 64'h0FFF_FFFF_FFFF_FFC5,
               64'h8000_0000_0000_0000, 64'd3, 64'd2, 64'h0000_0001_0000_0001};
        bs = '{1, 63, 0, 16, 63, 1, 7, 32};
        // directed: each special setting with edge coefficients
        foreach (qs[s]) begin
            write_reg(REG_MODULUS, qs[s]);
            write_reg(REG_BASE_BITS, 64'(bs[s]));
            send_coef(64'd0, 1'b0);
            send_coef(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
            drain();
        end

        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: write_reg(REG_MODULUS, rand64() | 64'h8000_0000_0000_0000);
                1: write_reg(REG_MODULUS, 64'($urandom_range(0, 300)));
                default: write_reg(REG_MODULUS, rand64() >> $urandom_range(0, 63));
            endcase
            write_reg(REG_BASE_BITS, (ph < 6) ? 64'($urandom_range(8, 63))
                                              : 64'($urandom_range(0, 63)));
            if (ph == 11) calm = 1'b1;
            for (int k = 0; k < 30; k++) begin
                c = rand64();
                if ($urandom_range(0, 7) == 0) c = ~64'd0;
                send_coef(c, 1'($urandom_range(0, 1)));
            end
            drain();
        end

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
